/* src/lrupr_pkg.sv */
// Shared constants and types for the LRU page replacement core.
package lrupr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 8;
  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 4;
  localparam int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NACT_W     = $clog2(MAX_FRAMES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_COMMIT
  } lrupr_state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
  } lrupr_cmd_t;

endpackage

/* src/lru_page_replacement_core.sv */
// Top level of the LRU page replacement core.
// One page reference is taken when start is high and busy is low; busy then stays high
// while the frames are searched and the table is updated, and the result appears on the
// out_ ports with out_valid high for exactly one cycle, registered from the commit step.
// A new reference can be taken in the cycle the result is shown; each item passes through the
// capture, search and commit steps of the controller before the next is taken. The
// receiver cannot stall results. cfg_we writes frames_in_use (0 acts as 1, above 8 as 8) and
// must only be used while busy is low.
module lru_page_replacement_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [lrupr_pkg::PAGE_BITS-1:0]     in_page,
  input  logic                                in_end_of_string,
  input  logic                                cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [lrupr_pkg::FIDX_W-1:0]        out_frame_slot,
  output logic                                out_evicted_valid,
  output logic [lrupr_pkg::PAGE_BITS-1:0]     out_evicted_page,
  output logic [lrupr_pkg::COUNT_BITS-1:0]    out_fault_count
);

  lrupr_pkg::lrupr_cmd_t cmd;

  lrupr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lrupr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_page           (in_page),
    .in_end_of_string  (in_end_of_string),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count)
  );

endmodule

/* src/lrupr_ctrl.sv */
// Controller state machine sequencing capture, decision and commit of one item.
module lrupr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output lrupr_pkg::lrupr_cmd_t cmd
);

  lrupr_pkg::lrupr_state_t state_r;
  lrupr_pkg::lrupr_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrupr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.decide  = 1'b0;
    cmd.commit  = 1'b0;
    busy        = 1'b1;
    unique case (state_r)
      lrupr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = lrupr_pkg::ST_DECIDE;
        end
      end
      lrupr_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = lrupr_pkg::ST_COMMIT;
      end
      lrupr_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = lrupr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrupr_pkg::ST_IDLE && start) |=> (state_r == lrupr_pkg::ST_DECIDE))
    else $error("accepted item did not enter decision");
  a_decide_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrupr_pkg::ST_DECIDE) |=> (state_r == lrupr_pkg::ST_COMMIT))
    else $error("decision not followed by commit");
  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrupr_pkg::ST_COMMIT) |=> (state_r == lrupr_pkg::ST_IDLE))
    else $error("commit not followed by idle");
`endif

endmodule

/* src/lrupr_dp.sv */
// Datapath: frame table, recency ranks, fault counter and result registers.
module lrupr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrupr_pkg::lrupr_cmd_t               cmd,
  input  logic [lrupr_pkg::PAGE_BITS-1:0]     in_page,
  input  logic                                in_end_of_string,
  input  logic                                cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wdata,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [lrupr_pkg::FIDX_W-1:0]        out_frame_slot,
  output logic                                out_evicted_valid,
  output logic [lrupr_pkg::PAGE_BITS-1:0]     out_evicted_page,
  output logic [lrupr_pkg::COUNT_BITS-1:0]    out_fault_count
);

  localparam int NF = lrupr_pkg::MAX_FRAMES;
  localparam int FW = lrupr_pkg::FIDX_W;
  localparam int PW = lrupr_pkg::PAGE_BITS;
  localparam int CW = lrupr_pkg::COUNT_BITS;
  localparam int AW = lrupr_pkg::NACT_W;

  logic [lrupr_pkg::CFG_W-1:0] frames_r;
  logic [PW-1:0]               frame_page_r [NF];
  logic [NF-1:0]               valid_r, valid_nxt;
  logic [FW-1:0]               rank_r [NF];
  logic [FW-1:0]               rank_nxt [NF];
  logic [CW-1:0]               count_r, count_nxt;
  logic [PW-1:0]               page_r;
  logic                        eos_r;

  logic                        dec_hit_r, dec_fill_r;
  logic [FW-1:0]               dec_slot_r;

  logic                        out_valid_r, out_hit_r, out_evicted_valid_r;
  logic [FW-1:0]               out_frame_slot_r;
  logic [PW-1:0]               out_evicted_page_r;
  logic [CW-1:0]               out_fault_count_r;

  logic [AW-1:0]               active_n;
  logic [NF-1:0]               active;
  logic                        hit_found, empty_found;
  logic [FW-1:0]               hit_idx, empty_idx, lru_idx;

  logic                        was_valid;
  logic [FW-1:0]               old_rank, others;
  logic [CW-1:0]               count_inc;
  logic [PW-1:0]               ev_page;

  always_comb begin
    if (frames_r == '0) begin
      active_n = AW'(1);
    end else if (frames_r > lrupr_pkg::CFG_W'(NF)) begin
      active_n = AW'(NF);
    end else begin
      active_n = frames_r[AW-1:0];
    end
    for (int j = 0; j < NF; j++) begin
      active[j] = (AW'(j) < active_n);
    end
  end

  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_idx     = '0;
    empty_idx   = '0;
    lru_idx     = '0;
    for (int j = NF - 1; j >= 0; j--) begin
      if (active[j] && valid_r[j] && frame_page_r[j] == page_r) begin
        hit_found = 1'b1;
        hit_idx   = FW'(j);
      end
      if (active[j] && !valid_r[j]) begin
        empty_found = 1'b1;
        empty_idx   = FW'(j);
      end
    end
    for (int j = 1; j < NF; j++) begin
      if (active[j] && rank_r[j] < rank_r[lru_idx]) begin
        lru_idx = FW'(j);
      end
    end
  end

  always_comb begin
    was_valid = dec_hit_r | ~dec_fill_r;
    old_rank  = rank_r[dec_slot_r];
    others    = '0;
    valid_nxt = valid_r;
    for (int j = 0; j < NF; j++) begin
      rank_nxt[j] = rank_r[j];
    end
    for (int j = 0; j < NF; j++) begin
      if (active[j] && valid_r[j] && FW'(j) != dec_slot_r) begin
        if (was_valid && rank_r[j] > old_rank) begin
          rank_nxt[j] = rank_r[j] - FW'(1);
        end
        others = others + FW'(1);
      end
    end
    rank_nxt[dec_slot_r]  = others;
    valid_nxt[dec_slot_r] = 1'b1;

    if (dec_hit_r || count_r == {CW{1'b1}}) begin
      count_inc = count_r;
    end else begin
      count_inc = count_r + CW'(1);
    end
    count_nxt = count_inc;

    ev_page = (!dec_hit_r && !dec_fill_r) ? frame_page_r[dec_slot_r] : '0;

    if (eos_r) begin
      valid_nxt = '0;
      count_nxt = '0;
      for (int j = 0; j < NF; j++) begin
        rank_nxt[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r    <= lrupr_pkg::CFG_W'(NF);
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NF; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        frames_r <= cfg_wdata;
      end
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
        for (int j = 0; j < NF; j++) begin
          rank_r[j] <= rank_nxt[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_page;
      eos_r  <= in_end_of_string;
    end
    if (cmd.decide) begin
      dec_hit_r  <= hit_found;
      dec_fill_r <= ~hit_found & empty_found;
      dec_slot_r <= hit_found ? hit_idx : (empty_found ? empty_idx : lru_idx);
    end
    if (cmd.commit) begin
      frame_page_r[dec_slot_r] <= page_r;
      out_hit_r                <= dec_hit_r;
      out_frame_slot_r         <= dec_slot_r;
      out_evicted_valid_r      <= ~dec_hit_r & ~dec_fill_r;
      out_evicted_page_r       <= ev_page;
      out_fault_count_r        <= count_inc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_frame_slot_r;
  assign out_evicted_valid = out_evicted_valid_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_count   = out_fault_count_r;

`ifndef NO_ASSERTIONS
  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.commit))
    else $error("result strobe without commit");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_evicted_valid_r)
    else $error("hit reported an eviction");
  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_evicted_valid_r) |-> (out_evicted_page_r == '0))
    else $error("evicted page nonzero without eviction");
`endif

endmodule
